// ===== rtl/core/kit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kit_pkg: shared definitions for the keyed item table
// Operation and status codes, controller states, stream widths and the
// item byte mask helper.
// ----------------------------------------------------------------------------
package kit_pkg;

  localparam int DEFAULT_MAX_ENTRIES    = 256;
  localparam int DEFAULT_MAX_ITEM_BYTES = 8;

  localparam int IN_TDATA_W  = 208;
  localparam int OUT_TDATA_W = 80;
  localparam int COUNT_OUT_W = 9;

  localparam logic [3:0] ITEM_BYTES_RESET = 4'd8;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_FIND   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST_RD,
    S_LAST_WR,
    S_READ_WAIT,
    S_RESP
  } state_t;

  // Keeps the low bytes of an item; a byte count of zero acts as one and
  // anything above the stored width acts as the stored width.
  function automatic logic [63:0] item_mask(input logic [3:0] nbytes,
                                            input logic [3:0] max_bytes);
    logic [3:0]  n;
    logic [63:0] m;
    n = nbytes;
    m = '0;
    if (n == 4'd0) n = 4'd1;
    if (n > max_bytes) n = max_bytes;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/keyed_item_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_item_table: linear table of 128-bit keys and their items
// Add, find, remove (last entry moves into the freed slot), read by index
// and clear, over key and item memories with a registered read.
// ----------------------------------------------------------------------------
// Usage:
//   Operations enter on the s_ stream and each gives exactly one result
//   on the m_ stream, in order. item_bytes is written through cfg_we and
//   cfg_wdata while the table is idle.
// Steps (accept to result valid):
//   add, clear and unused codes go straight to the result; read by index
//   waits on the memory read, unless the index is out of range.
//   Find scans the stored keys in order until a hit or the count; remove
//   on a hit then reads the last entry and writes it into the freed slot.
//   The worst case is set by the key scan, which reads one stored key per
//   cycle through the single read port.
// Throughput: one item at a time; the next item is taken as soon as the
//   previous result sits in the output register, even if it is not taken.
// Reset: the count goes to zero and item_bytes to 8, and s_tready stays low
//   while rst is high. The memories are not cleared; only entries below the
//   count are ever read.
// Stall: a result waits in the output register while m_tready is low, and
//   the block holds its next result until that register frees up.
// ----------------------------------------------------------------------------
module keyed_item_table #(
  parameter int MAX_ENTRIES    = kit_pkg::DEFAULT_MAX_ENTRIES,
  parameter int MAX_ITEM_BYTES = kit_pkg::DEFAULT_MAX_ITEM_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [3:0]                     cfg_wdata,  // item_bytes
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // op[2:0], key_high[66:3], key_low[130:67], item_data[194:131],
  // entry_index[202:195]
  input  logic [kit_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status[1:0], item_out[65:2], entry_count[74:66]
  output logic [kit_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IB = 8 * MAX_ITEM_BYTES;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

  // Input fields.
  logic [2:0]   in_op;
  logic [127:0] in_key;
  logic [63:0]  in_data;
  logic [7:0]   in_index;

  assign in_op    = s_tdata[2:0];
  assign in_key   = {s_tdata[66:3], s_tdata[130:67]};
  assign in_data  = s_tdata[194:131];
  assign in_index = s_tdata[202:195];

  // Memories.
  logic [127:0]  key_mem  [MAX_ENTRIES];
  logic [IB-1:0] item_mem [MAX_ENTRIES];
  logic [127:0]  key_rd;
  logic [IB-1:0] item_rd;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [127:0]  wr_key;
  logic [IB-1:0] wr_item;

  // Control and payload registers.
  kit_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [3:0]      item_bytes;
  logic [CW-1:0]   scan_addr, scan_addr_next;
  logic            cmp_valid, cmp_valid_next;
  logic [AW-1:0]   cmp_pos, cmp_pos_next;
  logic [AW-1:0]   rem_pos, rem_pos_next;
  logic [127:0]    key_hold, key_hold_next;
  logic [2:0]      op_hold, op_hold_next;
  kit_pkg::status_t res_status, res_status_next;
  logic [63:0]     res_item, res_item_next;
  logic            out_load;

  logic [63:0]   mask;
  logic [CW-1:0] last;
  logic          hit;
  logic          idx_ok;
  logic [31:0]   idx_wide;

  assign mask     = kit_pkg::item_mask(item_bytes, 4'(MAX_ITEM_BYTES));
  assign last     = count - CW'(1);
  assign hit      = cmp_valid && (key_rd == key_hold);
  assign idx_wide = 32'(in_index);
  assign idx_ok   = idx_wide < 32'(count);
  assign s_tready = (state == kit_pkg::S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      item_mem[wr_addr] <= wr_item;
    end
    key_rd  <= key_mem[rd_addr];
    item_rd <= item_mem[rd_addr];
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_addr_next  = scan_addr;
    cmp_valid_next  = 1'b0;
    cmp_pos_next    = cmp_pos;
    rem_pos_next    = rem_pos;
    key_hold_next   = key_hold;
    op_hold_next    = op_hold;
    res_status_next = res_status;
    res_item_next   = res_item;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_key          = in_key;
    wr_item         = IB'(in_data & mask);
    out_load        = 1'b0;
    unique case (state)
      kit_pkg::S_IDLE: begin
        if (s_tvalid) begin
          key_hold_next   = in_key;
          op_hold_next    = in_op;
          scan_addr_next  = '0;
          res_status_next = kit_pkg::ST_OK;
          res_item_next   = '0;
          state_next      = kit_pkg::S_RESP;
          case (in_op)
            kit_pkg::OP_ADD: begin
              if (count != FULL_COUNT) begin
                wr_en      = 1'b1;
                wr_addr    = count[AW-1:0];
                count_next = count + CW'(1);
              end else begin
                res_status_next = kit_pkg::ST_FULL;
              end
            end
            kit_pkg::OP_FIND, kit_pkg::OP_REMOVE: begin
              state_next = kit_pkg::S_SCAN;
            end
            kit_pkg::OP_READ: begin
              if (idx_ok) begin
                rd_addr    = idx_wide[AW-1:0];
                state_next = kit_pkg::S_READ_WAIT;
              end else begin
                res_status_next = kit_pkg::ST_RANGE;
              end
            end
            kit_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      kit_pkg::S_SCAN: begin
        // Keys are issued in order, so the first hit is the lowest match.
        if (hit) begin
          if (op_hold == kit_pkg::OP_FIND) begin
            res_item_next = 64'(item_rd) & mask;
            state_next    = kit_pkg::S_RESP;
          end else begin
            rem_pos_next = cmp_pos;
            state_next   = kit_pkg::S_LAST_RD;
          end
        end else if (scan_addr < count) begin
          rd_addr        = scan_addr[AW-1:0];
          cmp_valid_next = 1'b1;
          cmp_pos_next   = scan_addr[AW-1:0];
          scan_addr_next = scan_addr + CW'(1);
        end else if (!cmp_valid) begin
          res_status_next = kit_pkg::ST_NOT_FOUND;
          state_next      = kit_pkg::S_RESP;
        end
      end
      kit_pkg::S_LAST_RD: begin
        rd_addr    = last[AW-1:0];
        state_next = kit_pkg::S_LAST_WR;
      end
      kit_pkg::S_LAST_WR: begin
        wr_en      = 1'b1;
        wr_addr    = rem_pos;
        wr_key     = key_rd;
        wr_item    = item_rd;
        count_next = last;
        state_next = kit_pkg::S_RESP;
      end
      kit_pkg::S_READ_WAIT: begin
        res_item_next = 64'(item_rd) & mask;
        state_next    = kit_pkg::S_RESP;
      end
      kit_pkg::S_RESP: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = kit_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kit_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kit_pkg::S_IDLE;
      count      <= '0;
      item_bytes <= kit_pkg::ITEM_BYTES_RESET;
      cmp_valid  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
      if (cfg_we) begin
        item_bytes <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_addr  <= scan_addr_next;
    cmp_pos    <= cmp_pos_next;
    rem_pos    <= rem_pos_next;
    key_hold   <= key_hold_next;
    op_hold    <= op_hold_next;
    res_status <= res_status_next;
    res_item   <= res_item_next;
    if (out_load) begin
      m_tdata <= {5'b0, kit_pkg::COUNT_OUT_W'(count), res_item, res_status};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above table size");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == kit_pkg::S_SCAN && cmp_valid) |-> (CW'(cmp_pos) < count))
    else $error("compared entry lies beyond the count");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == kit_pkg::S_LAST_WR) |=> (count == $past(count) - CW'(1)))
    else $error("remove did not shrink the table by one");

  a_error_zero_item: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != kit_pkg::ST_OK) |-> (m_tdata[65:2] == 64'd0))
    else $error("error result carries item data");

  a_resp_in_order: assert property (@(posedge clk) disable iff (rst)
    (state == kit_pkg::S_RESP && m_tvalid && !m_tready) |=> (state == kit_pkg::S_RESP))
    else $error("result left while output register was full");
`endif

endmodule

// ===== bench/tb_keyed_item_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_item_table: self-checking bench for the keyed item table
// A queue of table operations feeds a stream driver with random gaps. A shadow
// table predicts each result, and a monitor with random back-pressure compares
// every returned item field by field. The item width register is changed
// between phases while entries stay in the table, and one phase fills the
// table past full.
// ----------------------------------------------------------------------------
module tb_keyed_item_table;

  localparam int TABLE_DEPTH  = kit_pkg::DEFAULT_MAX_ENTRIES;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD    = 600;
  localparam int PHASES       = 12;
  localparam logic [2:0] OP_SPARE_FIRST = 3'(kit_pkg::OP_CLEAR) + 3'd1;

  // Packed so that op lands in the lowest bits of s_tdata.
  typedef struct packed {
    logic [7:0]  entry_index;
    logic [63:0] item_data;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [2:0]  op;
  } table_op_t;

  typedef struct packed {
    logic [kit_pkg::COUNT_OUT_W-1:0] entry_count;
    logic [63:0]                     item_out;
    logic [1:0]                      status;
  } table_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [3:0]                      cfg_wdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  // op, key_high, key_low, item_data, entry_index
  logic [kit_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // status, item_out, entry_count
  logic [kit_pkg::OUT_TDATA_W-1:0] m_tdata;

  table_op_t     pending_ops[$];
  table_result_t expected_results[$];
  logic [127:0]  shadow_keys [TABLE_DEPTH];
  logic [63:0]   shadow_items [TABLE_DEPTH];
  int            shadow_count = 0;
  logic [3:0]    shadow_item_bytes = kit_pkg::ITEM_BYTES_RESET;
  logic [127:0]  key_pool [16];
  table_op_t     offered_op;
  int            send_gap;
  int            recv_gap;
  int            recv_hold;
  bit            idling_on = 1'b1;
  bit            sender_hold = 1'b0;
  bit            hold_request = 1'b0;
  int            error_count = 0;
  int            quiet_cycles = 0;

  keyed_item_table DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] kept_bytes_mask(input logic [3:0] nb);
    int n;
    n = (nb == 4'd0) ? 1 :
        (nb > 4'(kit_pkg::DEFAULT_MAX_ITEM_BYTES)) ? kit_pkg::DEFAULT_MAX_ITEM_BYTES :
        int'(nb);
    return (n == 8) ? '1 : (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic int match_position(input logic [127:0] k);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // Updates the shadow table for one accepted item and queues its result.
  task automatic apply_to_shadow(input table_op_t t);
    table_result_t r;
    logic [63:0]   keep;
    int            pos;
    keep = kept_bytes_mask(shadow_item_bytes);
    r.status = kit_pkg::ST_OK;
    r.item_out = '0;
    pos = match_position({t.key_high, t.key_low});
    case (t.op)
      kit_pkg::OP_ADD: begin
        if (shadow_count < TABLE_DEPTH) begin
          shadow_keys[shadow_count] = {t.key_high, t.key_low};
          shadow_items[shadow_count] = t.item_data & keep;
          shadow_count++;
        end else r.status = kit_pkg::ST_FULL;
      end
      kit_pkg::OP_FIND: begin
        if (pos >= 0) r.item_out = shadow_items[pos] & keep;
        else r.status = kit_pkg::ST_NOT_FOUND;
      end
      kit_pkg::OP_REMOVE: begin
        // The last entry moves into the freed slot.
        if (pos >= 0) begin
          shadow_count--;
          shadow_keys[pos] = shadow_keys[shadow_count];
          shadow_items[pos] = shadow_items[shadow_count];
        end else r.status = kit_pkg::ST_NOT_FOUND;
      end
      kit_pkg::OP_READ: begin
        if (int'(t.entry_index) < shadow_count)
          r.item_out = shadow_items[t.entry_index] & keep;
        else r.status = kit_pkg::ST_RANGE;
      end
      kit_pkg::OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.entry_count = kit_pkg::COUNT_OUT_W'(shadow_count);
    expected_results.push_back(r);
  endtask

  function automatic table_op_t make_op(input logic [2:0] op);
    table_op_t    t;
    logic [127:0] k;
    int           r;
    r = $urandom_range(0, 9);
    k = key_pool[$urandom_range(0, 15)];
    // Mostly pooled keys so finds and removes hit; some one-bit near misses.
    if (r == 7) k[$urandom_range(0, 127)] ^= 1'b1;
    else if (r > 7) k = {$urandom, $urandom, $urandom, $urandom};
    t.op = op;
    {t.key_high, t.key_low} = k;
    r = $urandom_range(0, 9);
    t.item_data = (r == 0) ? '1 : (r == 1) ? '0 : {$urandom, $urandom};
    r = $urandom_range(0, 19);
    t.entry_index = (r < 12) ? 8'($urandom_range(0, 7)) :
                    (r < 17) ? 8'($urandom_range(0, 40)) : 8'($urandom);
    return t;
  endfunction

  function automatic logic [2:0] pick_op(input int add_pct);
    int r;
    if ($urandom_range(0, 99) < add_pct) return kit_pkg::OP_ADD;
    r = $urandom_range(0, 99);
    if (r < 35) return kit_pkg::OP_FIND;
    if (r < 65) return kit_pkg::OP_REMOVE;
    if (r < 93) return kit_pkg::OP_READ;
    if (r < 97) return OP_SPARE_FIRST + 3'($urandom_range(0, 2));
    return kit_pkg::OP_CLEAR;
  endfunction

  task automatic push_op(input logic [2:0] op, input logic [127:0] k,
                         input logic [63:0] data, input logic [7:0] idx);
    table_op_t t;
    t.op = op;
    {t.key_high, t.key_low} = k;
    t.item_data = data;
    t.entry_index = idx;
    pending_ops.push_back(t);
  endtask

  task automatic queue_mix(input int n, input int add_pct);
    repeat (n) pending_ops.push_back(make_op(pick_op(add_pct)));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  task automatic write_item_bytes(input logic [3:0] nb);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= nb;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_item_bytes = nb;
  endtask

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : feed
    logic next_valid;
    next_valid = s_tvalid && !s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) apply_to_shadow(offered_op);
      if (!next_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_ops.size() != 0 && !sender_hold) begin
          if (idling_on && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 14);
          end else begin
            offered_op = pending_ops.pop_front();
            s_tdata <= kit_pkg::IN_TDATA_W'(offered_op);
            next_valid = 1'b1;
          end
        end
      end
      s_tvalid <= next_valid;
    end
  end

  always @(posedge clk) begin : collect
    table_result_t got;
    table_result_t want;
    logic          ready_next;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
      recv_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = table_result_t'(m_tdata[$bits(table_result_t)-1:0]);
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_field("status", 64'(want.status), 64'(got.status));
          if (got.item_out !== want.item_out)
            report_field("item_out", want.item_out, got.item_out);
          if (got.entry_count !== want.entry_count)
            report_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
        end
      end
      if (hold_request) begin
        recv_hold = LONG_HOLD;
        hold_request = 1'b0;
      end
      ready_next = 1'b1;
      if (recv_hold > 0) begin
        recv_hold--;
        ready_next = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ready_next = 1'b0;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 14);
        ready_next = 1'b0;
      end
      m_tready <= ready_next;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0] width_plan [PHASES];
    width_plan = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd9, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd12};
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = {64'd0, 64'd1};
    key_pool[3] = {64'h8000_0000_0000_0000, 64'd0};
    for (int i = 4; i < 16; i++) key_pool[i] = {$urandom, $urandom, $urandom, $urandom};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty table, duplicates, remove with a move, spare codes and clear.
    push_op(kit_pkg::OP_READ, '0, '0, 8'd0);
    push_op(kit_pkg::OP_FIND, '1, '1, 8'd0);
    push_op(kit_pkg::OP_REMOVE, '0, '0, 8'd0);
    push_op(kit_pkg::OP_ADD, '0, '1, '1);
    push_op(kit_pkg::OP_ADD, '1, 64'h0123_4567_89AB_CDEF, 8'd0);
    push_op(kit_pkg::OP_ADD, '0, 64'd5, 8'd0);
    push_op(kit_pkg::OP_FIND, '0, '0, 8'd0);
    push_op(kit_pkg::OP_FIND, {64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, '0, 8'd0);
    push_op(kit_pkg::OP_FIND, {64'd0, 64'd1}, '0, 8'd0);
    push_op(kit_pkg::OP_READ, '0, '0, 8'd2);
    push_op(kit_pkg::OP_READ, '0, '0, 8'd3);
    push_op(kit_pkg::OP_READ, '0, '0, 8'd255);
    push_op(kit_pkg::OP_REMOVE, '0, '0, 8'd0);
    push_op(kit_pkg::OP_READ, '0, '0, 8'd0);
    push_op(kit_pkg::OP_FIND, '1, '0, 8'd0);
    for (int c = 0; c < 3; c++) push_op(OP_SPARE_FIRST + 3'(c), '1, '1, 8'd0);
    push_op(kit_pkg::OP_CLEAR, '0, '0, 8'd0);
    push_op(kit_pkg::OP_READ, '0, '0, 8'd0);
    push_op(kit_pkg::OP_ADD, key_pool[4], '1, 8'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      write_item_bytes(width_plan[phase]);
      if (phase == PHASES - 1) idling_on = 1'b0;
      if (phase == 2) begin
        // Run the table past full, then read its top entry and work near full.
        repeat (TABLE_DEPTH + 3) pending_ops.push_back(make_op(kit_pkg::OP_ADD));
        push_op(kit_pkg::OP_READ, '0, '0, 8'd255);
        push_op(kit_pkg::OP_READ, '0, '0, 8'd0);
        queue_mix(20, 50);
      end
      queue_mix(110, (phase % 2 == 0) ? 45 : 30);
      if (phase == 5) begin
        while (pending_ops.size() > 60) @(negedge clk);
        hold_request = 1'b1;
      end
      if (phase == 7) begin
        while (pending_ops.size() > 50) @(negedge clk);
        sender_hold = 1'b1;
        while (expected_results.size() != 0 || s_tvalid) @(negedge clk);
        sender_hold = 1'b0;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
